// ===== hw/rtl/bbe_pkg.sv =====
package bbe_pkg;

	// frame limits and the widths that follow from them
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	// register field widths
	localparam int WID_W      = 11;
	localparam int HGT_W      = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;

	// reset dimensions
	localparam int WIDTH_RST  = 1024;
	localparam int HEIGHT_RST = 768;

	// per-channel sum over up to nine pixels
	localparam int SUM_W = 12;

	// fraction bits of the reciprocal used by the mean unit
	localparam int RECIP_SHIFT = 19;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_reg_t;

	// channel 0 red, 1 green, 2 blue (red in the low bits)
	typedef logic [2:0][7:0] pixel_t;

	// one line store entry: the two rows above, same column
	typedef struct packed {
		pixel_t older;
		pixel_t newer;
	} line_t;

	// one output pixel to compute: row and column selects over the window
	typedef struct packed {
		logic [2:0] rows;
		logic [2:0] cols;
		logic       fend;
		logic       last;
	} job_t;

endpackage

// ===== hw/rtl/bbe_line_ram.sv =====
module bbe_line_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/bbe_mean.sv =====
module bbe_mean (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bbe_pkg::pixel_t  win [3][3],
	input  bbe_pkg::job_t    job,
	output logic             out_valid,
	input  logic             out_ready,
	output bbe_pkg::pixel_t  out_pix,
	output logic             out_last,
	output logic             out_fend
);

	// floor(2^19 / (2n)) for the neighbour counts that occur
	function automatic logic [bbe_pkg::RECIP_SHIFT-1:0] recip(input logic [3:0] n);
		logic [bbe_pkg::RECIP_SHIFT-1:0] m;
		case (n)
			4'd1:    m = 19'd262144;
			4'd2:    m = 19'd131072;
			4'd3:    m = 19'd87381;
			4'd4:    m = 19'd65536;
			4'd6:    m = 19'd43690;
			4'd9:    m = 19'd29127;
			default: m = 19'd262144;
		endcase
		return m;
	endfunction

	logic en;

	// stage 1: masked sums and neighbour count
	logic [bbe_pkg::SUM_W-1:0] col_sum [3][3];
	logic [bbe_pkg::SUM_W-1:0] sum_d   [3];
	logic [1:0]                row_cnt, col_cnt;
	logic [3:0]                n_d;

	logic                      valid_s1;
	logic [bbe_pkg::SUM_W-1:0] sum_s1 [3];
	logic [3:0]                n_s1;
	logic                      last_s1, fend_s1;

	// stage 2: reciprocal multiply
	logic [bbe_pkg::SUM_W:0]   t_d    [3];
	logic [31:0]               prod_d [3];

	logic                      valid_s2;
	logic [bbe_pkg::SUM_W:0]   t_s2   [3];
	logic [8:0]                q0_s2  [3];
	logic [4:0]                d_s2;
	logic                      last_s2, fend_s2;

	// stage 3: one-step correction
	logic [13:0]               qd_d  [3];
	logic [bbe_pkg::SUM_W:0]   rem_d [3];
	logic [8:0]                q_d   [3];
	bbe_pkg::pixel_t           pix_d;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 3; k++) begin
				col_sum[c][k] = '0;
				for (int m = 0; m < 3; m++) begin
					if (job.rows[m] && job.cols[k]) begin
						col_sum[c][k] = col_sum[c][k] + bbe_pkg::SUM_W'(win[k][m][c]);
					end
				end
			end
			sum_d[c] = col_sum[c][0] + col_sum[c][1] + col_sum[c][2];
		end
		row_cnt = 2'(job.rows[0]) + 2'(job.rows[1]) + 2'(job.rows[2]);
		col_cnt = 2'(job.cols[0]) + 2'(job.cols[1]) + 2'(job.cols[2]);
		n_d     = 4'(row_cnt) * 4'(col_cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1  <= sum_d;
			n_s1    <= (n_d == 4'd0) ? 4'd1 : n_d;
			last_s1 <= job.last;
			fend_s1 <= job.fend;
		end
	end

	// rounded half up: (2s + n) / 2n
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			t_d[c]    = {sum_s1[c], 1'b0} + (bbe_pkg::SUM_W + 1)'(n_s1);
			prod_d[c] = 32'(t_d[c]) * 32'(recip(n_s1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				t_s2[c]  <= t_d[c];
				q0_s2[c] <= prod_d[c][bbe_pkg::RECIP_SHIFT+8:bbe_pkg::RECIP_SHIFT];
			end
			d_s2    <= {n_s1, 1'b0};
			last_s2 <= last_s1;
			fend_s2 <= fend_s1;
		end
	end

	// quotient estimate is low by at most one
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qd_d[c]  = 14'(q0_s2[c]) * 14'(d_s2);
			rem_d[c] = t_s2[c] - qd_d[c][bbe_pkg::SUM_W:0];
			q_d[c]   = (rem_d[c] >= (bbe_pkg::SUM_W + 1)'(d_s2)) ? q0_s2[c] + 9'd1 : q0_s2[c];
			pix_d[c] = (q_d[c] > 9'd255) ? 8'd255 : q_d[c][7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pix  <= pix_d;
			out_last <= last_s2;
			out_fend <= fend_s2;
		end
	end

endmodule

// ===== hw/rtl/box_blur_3x3_edge_aware_core.sv =====
// 3x3 edge-aware box blur, rgb raster stream in, blurred raster stream out
// intake: a new pixel is taken only once every result of the previous one is handed to the mean unit,
//   held back by the line store read turnaround and the single shared mean unit
// latency: a pixel's results pass the window load and the mean unit's sum, multiply and correction stages
// reset: counters to zero, width 1024, height 768, window cleared;
//   the line stores are not cleared and are written before any read reaches an output
module box_blur_3x3_edge_aware_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// pixel input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [23:0]                     s_tdata,   // in_red, in_green, in_blue
	// blurred pixel output
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [23:0]                     m_tdata,   // out_red, out_green, out_blue
	output logic                            m_tlast,   // run_last
	output logic                            m_tuser,   // frame_end
	// register writes
	input  logic                            cfg_we,
	input  logic [bbe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bbe_pkg::CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,   // waiting for a pixel, line store read issued on transfer
		ST_LOAD = 3'b010,   // store data back: shift window, write store, list results
		ST_EMIT = 3'b100    // hand listed results to the mean unit, one a cycle while it is ready
	} state_t;

	state_t                     state_q;

	// geometry, kept as last column and last row index
	logic [bbe_pkg::COL_W-1:0]  wm1_q, wm1_d;
	logic [bbe_pkg::ROW_W-1:0]  hm1_q, hm1_d;
	logic [bbe_pkg::WID_W-1:0]  cfg_w;
	logic [bbe_pkg::HGT_W-1:0]  cfg_h;

	// position of the pixel in flight / next pixel
	logic [bbe_pkg::COL_W-1:0]  col_q;
	logic [bbe_pkg::ROW_W-1:0]  row_q;

	bbe_pkg::pixel_t            pix_q;
	bbe_pkg::pixel_t            win_q [3][3];   // [column][row], column 2 newest

	// line store port
	logic                       ram_re, ram_we;
	bbe_pkg::line_t             ram_rdata, ram_wdata;

	// result list of the current pixel
	bbe_pkg::job_t              job_q [4];
	bbe_pkg::job_t              job_d [4];
	logic [3:0]                 pend_q, pend_d;
	logic [1:0]                 sel_idx;
	logic [3:0]                 rest;
	bbe_pkg::job_t              issue_job;
	logic                       issue_valid, issue_ready;
	logic                       i_ge1, i_ge2, j_ge1, j_ge2, i_last, j_last;

	assign s_tready = (state_q == ST_IDLE);

	// register decode with clipping of out-of-range dimensions
	always_comb begin
		cfg_w = cfg_data[bbe_pkg::WID_W-1:0];
		cfg_h = cfg_data[bbe_pkg::HGT_W-1:0];
		if (cfg_w == '0) begin
			wm1_d = '0;
		end else if (cfg_w > bbe_pkg::WID_W'(bbe_pkg::MAX_WIDTH)) begin
			wm1_d = bbe_pkg::COL_W'(bbe_pkg::MAX_WIDTH - 1);
		end else begin
			wm1_d = bbe_pkg::COL_W'(cfg_w - 1'b1);
		end
		if (cfg_h == '0) begin
			hm1_d = '0;
		end else if (cfg_h > bbe_pkg::HGT_W'(bbe_pkg::MAX_HEIGHT)) begin
			hm1_d = bbe_pkg::ROW_W'(bbe_pkg::MAX_HEIGHT - 1);
		end else begin
			hm1_d = bbe_pkg::ROW_W'(cfg_h - 1'b1);
		end
	end

	// line store: one entry per column holds the two rows above;
	// the write in ST_LOAD always lands before the next read, so a
	// one-pixel-wide frame needs no bypass
	assign ram_re    = s_tvalid && s_tready;
	assign ram_we    = (state_q == ST_LOAD);
	assign ram_wdata = '{older: ram_rdata.newer, newer: pix_q};

	bbe_line_ram #(
		.DEPTH (bbe_pkg::MAX_WIDTH),
		.WIDTH ($bits(bbe_pkg::line_t))
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	// results that this pixel completes, in raster order:
	// (row-1, col-1), (row-1, col), (row, col-1), (row, col)
	always_comb begin
		i_ge1  = (row_q != '0);
		i_ge2  = (row_q > bbe_pkg::ROW_W'(1));
		j_ge1  = (col_q != '0);
		j_ge2  = (col_q > bbe_pkg::COL_W'(1));
		i_last = (row_q == hm1_q);
		j_last = (col_q == wm1_q);

		// row mask bits: 0 two rows up, 1 one row up, 2 current row
		job_d[0] = '{rows: {1'b1, 1'b1, i_ge2}, cols: {1'b1, 1'b1, j_ge2}, fend: 1'b0, last: 1'b0};
		job_d[1] = '{rows: {1'b1, 1'b1, i_ge2}, cols: {1'b1, j_ge1, 1'b0}, fend: 1'b0, last: 1'b0};
		job_d[2] = '{rows: {1'b1, i_ge1, 1'b0}, cols: {1'b1, 1'b1, j_ge2}, fend: 1'b0, last: 1'b0};
		// bottom right corner of the frame only ever comes from this slot
		job_d[3] = '{rows: {1'b1, i_ge1, 1'b0}, cols: {1'b1, j_ge1, 1'b0}, fend: 1'b1, last: 1'b0};

		pend_d = {i_last && j_last, i_last && j_ge1, i_ge1 && j_last, i_ge1 && j_ge1};
	end

	// pick the lowest pending result
	always_comb begin
		sel_idx = 2'd0;
		for (int b = 3; b >= 0; b--) begin
			if (pend_q[b]) begin
				sel_idx = 2'(b);
			end
		end
		rest           = pend_q & ~(4'b0001 << sel_idx);
		issue_job      = job_q[sel_idx];
		issue_job.last = (rest == 4'b0000);
		issue_valid    = (state_q == ST_EMIT);
	end

	// sequencer, position counters and geometry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			pend_q  <= '0;
			wm1_q   <= bbe_pkg::COL_W'(bbe_pkg::WIDTH_RST - 1);
			hm1_q   <= bbe_pkg::ROW_W'(bbe_pkg::HEIGHT_RST - 1);
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					pend_q  <= pend_d;
					state_q <= (pend_d != 4'b0000) ? ST_EMIT : ST_IDLE;
					if (j_last) begin
						col_q <= '0;
						row_q <= i_last ? '0 : row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (issue_ready) begin
						pend_q <= rest;
						if (rest == 4'b0000) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// a register write restarts the frame
			if (cfg_we) begin
				case (cfg_index)
					bbe_pkg::CFG_WIDTH: begin
						wm1_q <= wm1_d;
						col_q <= '0;
						row_q <= '0;
					end
					bbe_pkg::CFG_HEIGHT: begin
						hm1_q <= hm1_d;
						col_q <= '0;
						row_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// incoming pixel and result list
	always_ff @(posedge clk) begin
		if (ram_re) begin
			pix_q <= s_tdata;
		end
		if (state_q == ST_LOAD) begin
			job_q <= job_d;
		end
	end

	// 3x3 window, shifts by one column per pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				for (int m = 0; m < 3; m++) begin
					win_q[k][m] <= '0;
				end
			end
		end else if (state_q == ST_LOAD) begin
			for (int m = 0; m < 3; m++) begin
				win_q[0][m] <= win_q[1][m];
				win_q[1][m] <= win_q[2][m];
			end
			win_q[2][0] <= ram_rdata.older;
			win_q[2][1] <= ram_rdata.newer;
			win_q[2][2] <= pix_q;
		end
	end

	// mean unit owns the output register
	bbe_mean u_mean (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (issue_valid),
		.in_ready  (issue_ready),
		.win       (win_q),
		.job       (issue_job),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pix   (m_tdata),
		.out_last  (m_tlast),
		.out_fend  (m_tuser)
	);

	// the corner result closes its pixel's run
	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame end without run last");

	// a store write always follows the transfer whose read it completes
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(s_tvalid && s_tready))
		else $error("line store write without preceding read");

	// nothing left to hand over means the sequencer has left the emit state
	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> pend_q != 4'b0000)
		else $error("emit state with empty result list");

	// position stays inside the programmed frame
	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= wm1_q) && (row_q <= hm1_q))
		else $error("position outside frame");

endmodule

// ===== bench/tb_box_blur_3x3_edge_aware_core.sv =====
`timescale 1ns / 1ps

module tb_box_blur_3x3_edge_aware_core;

	// one blurred pixel as it should leave the block
	typedef struct packed {
		bbe_pkg::pixel_t px;
		logic            last;
		logic            fend;
	} blur_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [23:0]                    s_tdata = '0;   // in_red, in_green, in_blue
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [23:0]                    m_tdata;        // out_red, out_green, out_blue
	logic                           m_tlast;        // run_last
	logic                           m_tuser;        // frame_end
	logic                           cfg_we = 1'b0;
	bbe_pkg::cfg_reg_t              cfg_index = bbe_pkg::CFG_WIDTH;
	logic [bbe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	box_blur_3x3_edge_aware_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// pixels waiting for the driver, blurred pixels waiting for the block
	bbe_pkg::pixel_t pix_q[$];
	blur_t           blur_q[$];

	// while set, neither side idles
	bit steady = 1'b0;
	int errors = 0;

	// --------------------------------------------------------------------
	// blur predictor: own copy of line stores, window, position and size
	// --------------------------------------------------------------------
	bbe_pkg::pixel_t older_row [bbe_pkg::MAX_WIDTH];
	bbe_pkg::pixel_t newer_row [bbe_pkg::MAX_WIDTH];
	bbe_pkg::pixel_t win [3][3];   // [column][row], column 2 and row 2 newest
	int              row_pos = 0;
	int              col_pos = 0;
	int              frame_w = bbe_pkg::WIDTH_RST;
	int              frame_h = bbe_pkg::HEIGHT_RST;

	// zero means one, anything above the store size saturates
	function automatic int clamp_dim(int v, int maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// rounded mean of the clipped neighborhood of (r, c); newest window pixel is (i, j)
	function automatic blur_t blur_pixel(int r, int c, int i, int j);
		int    r0, r1, c0, c1, rr, cc, m, k, ch, cnt;
		int    sum [3];
		blur_t res;
		r0 = (r > 0) ? r - 1 : 0;
		r1 = (r + 1 < frame_h) ? r + 1 : frame_h - 1;
		c0 = (c > 0) ? c - 1 : 0;
		c1 = (c + 1 < frame_w) ? c + 1 : frame_w - 1;
		sum = '{0, 0, 0};
		cnt = 0;
		for (rr = r0; rr <= r1; rr++) begin
			for (cc = c0; cc <= c1; cc++) begin
				m = rr - i + 2;
				k = cc - j + 2;
				if (m >= 0 && m <= 2 && k >= 0 && k <= 2) begin
					for (ch = 0; ch < 3; ch++)
						sum[ch] += win[k][m][ch];
					cnt++;
				end
			end
		end
		if (cnt == 0)
			cnt = 1;
		// half up, exact: (2s + n) / 2n
		for (ch = 0; ch < 3; ch++)
			res.px[ch] = 8'((2 * sum[ch] + cnt) / (2 * cnt));
		res.last = 1'b0;
		res.fend = (r == frame_h - 1 && c == frame_w - 1);
		return res;
	endfunction

	// one accepted pixel: update stores and window, queue what it completes
	function automatic void blur_accept(bbe_pkg::pixel_t pix);
		int              i, j, k;
		bbe_pkg::pixel_t above2, above1;
		blur_t           done[$];
		j = col_pos;
		i = row_pos;
		if (j >= frame_w)
			j = 0;
		if (i >= frame_h)
			i = 0;
		above2 = older_row[j];
		above1 = newer_row[j];
		older_row[j] = above1;
		newer_row[j] = pix;
		for (k = 0; k < 3; k++) begin
			win[0][k] = win[1][k];
			win[1][k] = win[2][k];
		end
		win[2][0] = above2;
		win[2][1] = above1;
		win[2][2] = pix;
		// row above finishes here, then the current row if it is the bottom one
		if (i >= 1) begin
			if (j >= 1)
				done.push_back(blur_pixel(i - 1, j - 1, i, j));
			if (j == frame_w - 1)
				done.push_back(blur_pixel(i - 1, j, i, j));
		end
		if (i == frame_h - 1) begin
			if (j >= 1)
				done.push_back(blur_pixel(i, j - 1, i, j));
			if (j == frame_w - 1)
				done.push_back(blur_pixel(i, j, i, j));
		end
		if (done.size() > 0)
			done[done.size() - 1].last = 1'b1;
		foreach (done[n])
			blur_q.push_back(done[n]);
		j++;
		if (j >= frame_w) begin
			j = 0;
			i++;
			if (i >= frame_h)
				i = 0;
		end
		col_pos = j;
		row_pos = i;
	endfunction

	// --------------------------------------------------------------------
	// driver: one pixel per transfer, random idle cycles
	// --------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				blur_accept(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (pix_q.size() != 0 && (steady || $urandom_range(99) >= 17)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pix_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// --------------------------------------------------------------------
	// monitor: random stalls, each transfer checked against the oldest expectation
	// --------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		blur_t exp_px;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (blur_q.size() == 0) begin
					errors++;
					if (errors <= 20)
						$display("%0t unexpected transfer: expected none, got rgb %h last %b fend %b",
							$time, m_tdata, m_tlast, m_tuser);
				end else begin
					exp_px = blur_q.pop_front();
					if (m_tdata !== exp_px.px || m_tlast !== exp_px.last ||
					    m_tuser !== exp_px.fend) begin
						errors++;
						if (errors <= 20)
							$display("%0t mismatch: expected rgb %h last %b fend %b, got rgb %h last %b fend %b",
								$time, exp_px.px, exp_px.last, exp_px.fend,
								m_tdata, m_tlast, m_tuser);
					end
				end
			end
			m_tready <= steady || $urandom_range(99) >= 17;
		end
	end

	// --------------------------------------------------------------------
	// stimulus
	// --------------------------------------------------------------------

	// channels mostly random, now and then pinned to an extreme
	function automatic bbe_pkg::pixel_t rand_pix();
		bbe_pkg::pixel_t p;
		int              ch;
		for (ch = 0; ch < 3; ch++) begin
			case ($urandom_range(7))
				0: p[ch] = 8'h00;
				1: p[ch] = 8'hFF;
				default: p[ch] = 8'($urandom_range(255));
			endcase
		end
		return p;
	endfunction

	// sender holds until every pixel is taken and every result is back
	task automatic wait_results();
		while (pix_q.size() != 0 || s_tvalid || blur_q.size() != 0)
			@(posedge clk);
	endtask

	// idle block: also covers pixels still in flight that complete nothing
	task automatic drain();
		wait_results();
		repeat (10) @(posedge clk);
	endtask

	// register write; the frame restarts from the top left corner
	task automatic write_reg(bbe_pkg::cfg_reg_t idx, logic [bbe_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bbe_pkg::CFG_WIDTH)
			frame_w = clamp_dim(int'(val[bbe_pkg::WID_W-1:0]), bbe_pkg::MAX_WIDTH);
		else
			frame_h = clamp_dim(int'(val[bbe_pkg::HGT_W-1:0]), bbe_pkg::MAX_HEIGHT);
		row_pos = 0;
		col_pos = 0;
	endtask

	task automatic push_pixels(int count);
		repeat (count) pix_q.push_back(rand_pix());
	endtask

	initial begin
		int              w, hgt, total, split, rand_items, n;
		bbe_pkg::pixel_t p;
		foreach (win[a, b])
			win[a][b] = '0;
		foreach (older_row[a]) begin
			older_row[a] = '0;
			newer_row[a] = '0;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size 1024 x 768: the start of the top row completes nothing
		push_pixels(4);
		drain();

		// 3 x 3 frame of full-scale pixels, then one of extremes
		write_reg(bbe_pkg::CFG_WIDTH, 13'd3);
		write_reg(bbe_pkg::CFG_HEIGHT, 13'd3);
		repeat (9) pix_q.push_back({8'hFF, 8'hFF, 8'hFF});
		for (n = 0; n < 9; n++) begin
			p[0] = $urandom_range(1) ? 8'hFF : 8'h00;
			p[1] = $urandom_range(1) ? 8'hFF : 8'h00;
			p[2] = $urandom_range(1) ? 8'hFF : 8'h00;
			pix_q.push_back(p);
		end
		drain();

		// zero size reads as one: every pixel is its own frame
		write_reg(bbe_pkg::CFG_WIDTH, 13'd0);
		write_reg(bbe_pkg::CFG_HEIGHT, 13'd0);
		push_pixels(2);
		drain();

		// one column, bits above the width field must be ignored
		write_reg(bbe_pkg::CFG_WIDTH, 13'h1801);
		write_reg(bbe_pkg::CFG_HEIGHT, 13'd3);
		push_pixels(3);
		drain();

		// widest frame, width saturated from all ones: no wrap after a few pixels
		write_reg(bbe_pkg::CFG_WIDTH, 13'h07FF);
		write_reg(bbe_pkg::CFG_HEIGHT, 13'd2);
		push_pixels(6);
		drain();

		// tallest frame, height saturated from all ones
		write_reg(bbe_pkg::CFG_WIDTH, 13'd1);
		write_reg(bbe_pkg::CFG_HEIGHT, 13'h1FFF);
		push_pixels(4);
		drain();

		// whole 10 x 3 frame with no idling on either side
		steady = 1'b1;
		write_reg(bbe_pkg::CFG_WIDTH, 13'd10);
		write_reg(bbe_pkg::CFG_HEIGHT, 13'd3);
		push_pixels(30);
		drain();
		steady = 1'b0;

		// random small frames, some wrapping into a second frame, some cut short
		rand_items = 0;
		while (rand_items < 50) begin
			if ($urandom_range(7) == 0) begin
				w   = $urandom_range(7, 12);
				hgt = $urandom_range(1, 3);
			end else begin
				w   = $urandom_range(1, 6);
				hgt = $urandom_range(1, 5);
			end
			if ($urandom_range(1)) begin
				write_reg(bbe_pkg::CFG_WIDTH, 13'(w));
				write_reg(bbe_pkg::CFG_HEIGHT, 13'(hgt));
			end else begin
				write_reg(bbe_pkg::CFG_HEIGHT, 13'(hgt));
				write_reg(bbe_pkg::CFG_WIDTH, 13'(w));
			end
			total = w * hgt * (($urandom_range(3) == 0) ? 2 : 1);
			// broken frame: the next register write restarts it
			if ($urandom_range(5) == 0)
				total = $urandom_range(1, w * hgt);
			// keep the run near its pixel budget
			if (rand_items + total > 55)
				total = 55 - rand_items;
			split = ($urandom_range(2) == 0) ? $urandom_range(1, total) : total + 1;
			for (n = 0; n < total; n++) begin
				if (n == split)
					wait_results();
				pix_q.push_back(rand_pix());
			end
			rand_items += total;
			drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
